// ----- rtl/dnrs_pkg.sv -----
// shared types, widths and constants for the directional nearest rectangle search
package dnrs_pkg;

  // field widths
  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = 15;
  localparam int ID_BITS    = 8;
  localparam int DIR_BITS   = 2;
  localparam int SCORE_BITS = 31;

  // score weight on the gap along the search axis
  localparam int GAP_WEIGHT   = 1000;
  localparam int GAP_WEIGHT_W = 10;

  // internal arithmetic widths, sized so nothing wraps
  localparam int EXT_W  = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : (SIZE_BITS + 1)) + 2;
  localparam int DIFF_W = EXT_W + 1;
  localparam int PROD_W = DIFF_W + GAP_WEIGHT_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CMP_W  = (SUM_W > SCORE_BITS) ? SUM_W : SCORE_BITS;

  localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

  typedef enum logic [DIR_BITS-1:0] {
    SEEK_LEFT  = 2'd0,
    SEEK_RIGHT = 2'd1,
    SEEK_UP    = 2'd2,
    SEEK_DOWN  = 2'd3
  } dir_t;

  typedef enum logic {
    CMD_START     = 1'b0,
    CMD_CANDIDATE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]         w;
    logic [SIZE_BITS-1:0]         h;
  } rect_t;

  typedef struct packed {
    cmd_t               command;
    rect_t              rect;
    dir_t               direction;
    logic [ID_BITS-1:0] candidate_id;
    logic               is_focused;
    logic               last;
  } item_t;

  // candidate evaluation handed from the scorer to the top level
  typedef struct packed {
    logic             hit;
    logic [CMP_W-1:0] score;
  } cand_eval_t;

endpackage

// ----- rtl/dnrs_if.sv -----
// valid/ready channel interfaces for query items and search results
interface dnrs_in_if;
  import dnrs_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [COORD_BITS-1:0] rect_x;
  logic signed [COORD_BITS-1:0] rect_y;
  logic [SIZE_BITS-1:0]         rect_w;
  logic [SIZE_BITS-1:0]         rect_h;
  logic [DIR_BITS-1:0]          direction;
  logic [ID_BITS-1:0]           candidate_id;
  logic                         is_focused;
  logic                         last;

  modport source (
    output valid, command, rect_x, rect_y, rect_w, rect_h, direction,
           candidate_id, is_focused, last,
    input  ready
  );
  modport sink (
    input  valid, command, rect_x, rect_y, rect_w, rect_h, direction,
           candidate_id, is_focused, last,
    output ready
  );
endinterface

interface dnrs_out_if;
  import dnrs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [ID_BITS-1:0]    best_id;
  logic [SCORE_BITS-1:0] min_score;

  modport source (
    output valid, found, best_id, min_score,
    input  ready
  );
  modport sink (
    input  valid, found, best_id, min_score,
    output ready
  );
endinterface

// ----- rtl/dnrs_score.sv -----
// candidate scorer: direction test, edge gap and centre offset
module dnrs_score (
  input  dnrs_pkg::rect_t      focus,
  input  dnrs_pkg::dir_t       dir,
  input  dnrs_pkg::rect_t      cand,
  output dnrs_pkg::cand_eval_t eval
);
  import dnrs_pkg::*;

  logic signed [EXT_W-1:0]  f_left, f_top, f_right, f_bottom, f_cx, f_cy;
  logic signed [EXT_W-1:0]  c_left, c_top, c_right, c_bottom, c_cx, c_cy;
  logic signed [DIFF_W-1:0] gap_s, off_s;
  logic [DIFF_W-1:0]        gap_mag, off_mag;
  logic [PROD_W-1:0]        gap_scaled;
  logic [SUM_W-1:0]         score_sum;
  logic                     beyond;

  // edges and truncated centres, widened
  always_comb begin
    f_left   = EXT_W'(focus.x);
    f_top    = EXT_W'(focus.y);
    f_right  = f_left + EXT_W'(focus.w);
    f_bottom = f_top + EXT_W'(focus.h);
    f_cx     = f_left + EXT_W'(focus.w >> 1);
    f_cy     = f_top + EXT_W'(focus.h >> 1);
    c_left   = EXT_W'(cand.x);
    c_top    = EXT_W'(cand.y);
    c_right  = c_left + EXT_W'(cand.w);
    c_bottom = c_top + EXT_W'(cand.h);
    c_cx     = c_left + EXT_W'(cand.w >> 1);
    c_cy     = c_top + EXT_W'(cand.h >> 1);
  end

  // direction test, gap along the axis and offset across it
  always_comb begin
    case (dir)
      SEEK_LEFT: begin
        beyond = (c_right <= f_left);
        gap_s  = DIFF_W'(f_left) - DIFF_W'(c_right);
        off_s  = DIFF_W'(c_cy) - DIFF_W'(f_cy);
      end
      SEEK_RIGHT: begin
        beyond = (c_left >= f_right);
        gap_s  = DIFF_W'(c_left) - DIFF_W'(f_right);
        off_s  = DIFF_W'(c_cy) - DIFF_W'(f_cy);
      end
      SEEK_UP: begin
        beyond = (c_bottom <= f_top);
        gap_s  = DIFF_W'(f_top) - DIFF_W'(c_bottom);
        off_s  = DIFF_W'(c_cx) - DIFF_W'(f_cx);
      end
      default: begin
        beyond = (c_top >= f_bottom);
        gap_s  = DIFF_W'(c_top) - DIFF_W'(f_bottom);
        off_s  = DIFF_W'(c_cx) - DIFF_W'(f_cx);
      end
    endcase
  end

  // gap is non-negative whenever the candidate is beyond the edge
  always_comb begin
    gap_mag    = gap_s;
    off_mag    = off_s[DIFF_W-1] ? DIFF_W'(-off_s) : DIFF_W'(off_s);
    gap_scaled = PROD_W'(gap_mag) * PROD_W'(GAP_WEIGHT);
    score_sum  = SUM_W'(gap_scaled) + SUM_W'(off_mag);
    eval.hit   = beyond;
    eval.score = CMP_W'(score_sum);
  end

endmodule

// ----- rtl/directional_nearest_rect_select.sv -----
// top level: directional nearest rectangle search with a running minimum
//
//  channel  | port    | direction | moves
//  ---------+---------+-----------+----------------------------------------
//  query    | in_chan | sink      | start or candidate rectangle, id, last
//  result   | out_chan| source    | found, best id, min score
//
// one transaction per cycle: each accepted item waits in the input register,
// where the scorer and the running minimum update it in one pass.
// the item marked last loads the result register. reset (rst_n low,
// synchronous) clears the focused rectangle to zero, direction left, and
// the running minimum. a stalled result only holds an item that carries
// last; other candidates keep flowing.
module directional_nearest_rect_select (
  input logic     clk,
  input logic     rst_n,
  dnrs_in_if.sink   in_chan,
  dnrs_out_if.source out_chan
);
  import dnrs_pkg::*;

  logic                  stg_valid_r;
  item_t                 stg_item_r;
  rect_t                 focus_r, focus_nxt;
  dir_t                  dir_r, dir_nxt;
  logic [SCORE_BITS-1:0] lowest_score_r, lowest_score_nxt;
  logic [ID_BITS-1:0]    chosen_id_r, chosen_id_nxt;
  logic                  have_choice_r, have_choice_nxt;
  logic                  out_valid_r;
  logic                  found_r;
  logic [ID_BITS-1:0]    best_id_r;
  logic [SCORE_BITS-1:0] min_score_r;
  logic                  stg_adv;
  logic                  in_take;
  logic                  take_cand;
  item_t                 in_item;
  cand_eval_t            cand_eval;

  // input register advances unless a last item meets a stalled result
  assign stg_adv        = stg_valid_r && (!stg_item_r.last || !out_valid_r || out_chan.ready);
  assign in_chan.ready  = !stg_valid_r || stg_adv;
  assign in_take        = in_chan.valid && in_chan.ready;

  always_comb begin
    in_item.command      = cmd_t'(in_chan.command);
    in_item.rect.x       = in_chan.rect_x;
    in_item.rect.y       = in_chan.rect_y;
    in_item.rect.w       = in_chan.rect_w;
    in_item.rect.h       = in_chan.rect_h;
    in_item.direction    = dir_t'(in_chan.direction);
    in_item.candidate_id = in_chan.candidate_id;
    in_item.is_focused   = in_chan.is_focused;
    in_item.last         = in_chan.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      stg_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_item_r <= in_item;
    end
  end

  dnrs_score u_score (
    .focus (focus_r),
    .dir   (dir_r),
    .cand  (stg_item_r.rect),
    .eval  (cand_eval)
  );

  // strict running minimum, first candidate keeps ties
  assign take_cand = (stg_item_r.command == CMD_CANDIDATE) && !stg_item_r.is_focused
                     && cand_eval.hit && (cand_eval.score < CMP_W'(lowest_score_r));

  always_comb begin
    focus_nxt        = focus_r;
    dir_nxt          = dir_r;
    lowest_score_nxt = lowest_score_r;
    chosen_id_nxt    = chosen_id_r;
    have_choice_nxt  = have_choice_r;
    if (stg_item_r.command == CMD_START) begin
      focus_nxt        = stg_item_r.rect;
      dir_nxt          = stg_item_r.direction;
      lowest_score_nxt = SCORE_MAX;
      chosen_id_nxt    = '0;
      have_choice_nxt  = 1'b0;
    end else if (take_cand) begin
      lowest_score_nxt = cand_eval.score[SCORE_BITS-1:0];
      chosen_id_nxt    = stg_item_r.candidate_id;
      have_choice_nxt  = 1'b1;
    end
  end

  // search state; the running minimum is cleared again after each result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focus_r        <= '0;
      dir_r          <= SEEK_LEFT;
      lowest_score_r <= SCORE_MAX;
      chosen_id_r    <= '0;
      have_choice_r  <= 1'b0;
    end else if (stg_adv) begin
      focus_r <= focus_nxt;
      dir_r   <= dir_nxt;
      if (stg_item_r.last) begin
        lowest_score_r <= SCORE_MAX;
        chosen_id_r    <= '0;
        have_choice_r  <= 1'b0;
      end else begin
        lowest_score_r <= lowest_score_nxt;
        chosen_id_r    <= chosen_id_nxt;
        have_choice_r  <= have_choice_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_adv && stg_item_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && stg_item_r.last) begin
      found_r     <= have_choice_nxt;
      best_id_r   <= chosen_id_nxt;
      min_score_r <= lowest_score_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.found     = found_r;
  assign out_chan.best_id   = best_id_r;
  assign out_chan.min_score = min_score_r;

  // checks
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !found_r |-> best_id_r == '0 && min_score_r == SCORE_MAX)
    else $error("empty result carries an id or a score");

  a_found_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && found_r |-> min_score_r != SCORE_MAX)
    else $error("found result with saturated score");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    stg_adv && stg_item_r.last |=> !have_choice_r && lowest_score_r == SCORE_MAX)
    else $error("running minimum not cleared after a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !stg_adv |-> !in_chan.ready)
    else $error("input register overwritten while held");

endmodule
